/* sv/dmph_pkg.sv */
// Package for the dual-modulus polynomial hash block.
// Holds the widths, register codes, beat structs, FSM states and control structs.
// No dependencies.
package dmph_pkg;

    // Field and datapath widths.
    localparam int HASH_W    = 31;
    localparam int BYTE_W    = 8;
    localparam int PROD_W    = 2 * HASH_W;
    localparam int CNT_W     = $clog2(PROD_W);
    localparam int CFG_IDX_W = 2;

    // Highest byte value that counts as ASCII.
    localparam logic [BYTE_W-1:0] ASCII_MAX = BYTE_W'(127);

    // Register reset values.
    localparam logic [HASH_W-1:0] BASE_RST    = HASH_W'(131);
    localparam logic [HASH_W-1:0] MOD_ONE_RST = HASH_W'(1000000007);
    localparam logic [HASH_W-1:0] MOD_TWO_RST = HASH_W'(998244353);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE    = 2'd0,
        CFG_MOD_ONE = 2'd1,
        CFG_MOD_TWO = 2'd2
    } t_cfg_idx;

    // Input and output beats.
    typedef struct packed {
        logic [BYTE_W-1:0] byte_in;
        logic              start_new;
    } t_in_beat;

    typedef struct packed {
        logic [HASH_W-1:0] hash_first;
        logic [HASH_W-1:0] hash_second;
        logic              bad_char;
    } t_out_beat;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_RED,
        ST_FIN
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load_in;
        logic mul;
        logic step;
        logic commit;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic bad;
        logic last;
    } t_sts;

endpackage

/* sv/dual_modulus_polynomial_hash_top.sv */
// Top level of the dual-modulus polynomial hash block.
// Joins the controller and the datapath; depends on dmph_pkg, dmph_ctrl and dmph_dp.
//
//   Channel | Direction | Handshake             | Beat
//   in      | input     | i_in_valid/o_in_stall | byte_in, start_new
//   out     | output    | o_out_valid/i_out_stall | hash_first, hash_second, bad_char
//   cfg     | input     | i_cfg_valid/o_cfg_ready | register index, write data
//
// An ASCII byte is captured on acceptance; then the product is formed, 62 remainder steps
// follow for the 62-bit product, and a commit loads the result.
// A non-ASCII byte skips the product and the remainder steps, goes straight to the commit,
// and leaves both hashes unchanged.
// Reset is synchronous and active low; it restores the register defaults and clears
// both hashes. A held result stalls the commit, and no new byte is accepted until the commit.
module dual_modulus_polynomial_hash_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  dmph_pkg::t_in_beat                 i_in_beat,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output dmph_pkg::t_out_beat                o_out_beat,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dmph_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dmph_pkg::HASH_W-1:0]        i_cfg_data
);
    import dmph_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Register writes are always taken.
    assign o_cfg_ready = 1'b1;

    // Sequencing.
    dmph_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Arithmetic and storage.
    dmph_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_beat   (i_in_beat),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_beat  (o_out_beat)
    );

endmodule

/* sv/dmph_ctrl.sv */
// Controller state machine for the dual-modulus polynomial hash block.
// Sequences load, multiply, bit-serial reduction and result hand-off.
// Depends on dmph_pkg.
module dmph_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  dmph_pkg::t_sts i_sts,
    output dmph_pkg::t_cmd o_cmd
);
    import dmph_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // The output register can take a new beat when empty or being drained.
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    // State and output-valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_MUL;
                end
            end
            ST_MUL: begin
                if (i_sts.bad) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = ST_RED;
                end
            end
            ST_RED: begin
                o_cmd.step = 1'b1;
                if (i_sts.last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // A commit fills the output register; an unstalled beat empties it.
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

endmodule

/* sv/dmph_dp.sv */
// Datapath for the dual-modulus polynomial hash block.
// Holds configuration, running hashes, one multiplier pair and two bit-serial remainders.
// Depends on dmph_pkg.
module dmph_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  dmph_pkg::t_in_beat                   i_in_beat,
    input  logic                                 i_cfg_we,
    input  logic [dmph_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [dmph_pkg::HASH_W-1:0]          i_cfg_data,
    input  dmph_pkg::t_cmd                       i_cmd,
    output dmph_pkg::t_sts                       o_sts,
    output dmph_pkg::t_out_beat                  o_out_beat
);
    import dmph_pkg::*;

    logic [HASH_W-1:0] r_base, r_mod1, r_mod2;
    logic [HASH_W-1:0] r_run1, r_run2;
    logic [BYTE_W-1:0] r_byte;
    logic              r_start, r_bad;
    logic [PROD_W-1:0] r_sum1, r_sum2;
    logic [HASH_W-1:0] r_rem1, r_rem2;
    logic [CNT_W-1:0]  r_cnt;
    t_out_beat         r_out;

    logic [HASH_W-1:0] h1, h2;
    logic [PROD_W-1:0] n_sum1, n_sum2;
    logic [HASH_W:0]   m1_eff, m2_eff, sh1, sh2;
    logic [HASH_W-1:0] n_rem1, n_rem2;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RST;
            r_mod1 <= MOD_ONE_RST;
            r_mod2 <= MOD_TWO_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BASE:    r_base <= i_cfg_data;
                CFG_MOD_ONE: r_mod1 <= i_cfg_data;
                CFG_MOD_TWO: r_mod2 <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // Product plus byte, with the running hash cleared on a start beat.
    assign h1     = r_start ? '0 : r_run1;
    assign h2     = r_start ? '0 : r_run2;
    assign n_sum1 = PROD_W'(h1) * PROD_W'(r_base) + PROD_W'(r_byte);
    assign n_sum2 = PROD_W'(h2) * PROD_W'(r_base) + PROD_W'(r_byte);

    // A modulus of zero or one behaves as one.
    assign m1_eff = (r_mod1 < HASH_W'(2)) ? (HASH_W+1)'(1) : {1'b0, r_mod1};
    assign m2_eff = (r_mod2 < HASH_W'(2)) ? (HASH_W+1)'(1) : {1'b0, r_mod2};

    // One restoring remainder step per cycle, most significant bit first.
    assign sh1    = {r_rem1, r_sum1[PROD_W-1]};
    assign sh2    = {r_rem2, r_sum2[PROD_W-1]};
    assign n_rem1 = (sh1 >= m1_eff) ? HASH_W'(sh1 - m1_eff) : HASH_W'(sh1);
    assign n_rem2 = (sh2 >= m2_eff) ? HASH_W'(sh2 - m2_eff) : HASH_W'(sh2);

    // Input capture, multiply and reduction registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_byte  <= i_in_beat.byte_in;
            r_start <= i_in_beat.start_new;
            r_bad   <= (i_in_beat.byte_in > ASCII_MAX);
        end
        if (i_cmd.mul) begin
            r_sum1 <= n_sum1;
            r_sum2 <= n_sum2;
            r_rem1 <= '0;
            r_rem2 <= '0;
            r_cnt  <= CNT_W'(PROD_W - 1);
        end else if (i_cmd.step) begin
            r_sum1 <= {r_sum1[PROD_W-2:0], 1'b0};
            r_sum2 <= {r_sum2[PROD_W-2:0], 1'b0};
            r_rem1 <= n_rem1;
            r_rem2 <= n_rem2;
            r_cnt  <= r_cnt - CNT_W'(1);
        end
    end

    // Running hashes are state and are cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run1 <= '0;
            r_run2 <= '0;
        end else if (i_cmd.commit && !r_bad) begin
            r_run1 <= r_rem1;
            r_run2 <= r_rem2;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.hash_first  <= r_bad ? r_run1 : r_rem1;
            r_out.hash_second <= r_bad ? r_run2 : r_rem2;
            r_out.bad_char    <= r_bad;
        end
    end

    assign o_sts.bad  = r_bad;
    assign o_sts.last = (r_cnt == '0);
    assign o_out_beat = r_out;

endmodule

/* test/tb.sv */
// Self-checking testbench for dual_modulus_polynomial_hash_top.
// It predicts both running hashes for every accepted byte, under varied register settings.
// Depends on dmph_pkg and dual_modulus_polynomial_hash_top.
`timescale 1ns / 1ps

module tb;
    import dmph_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_beat             i_in_beat = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_beat            o_out_beat;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [HASH_W-1:0]    i_cfg_data = '0;

    // Bytes waiting to be sent, and hash results waiting to come back.
    t_in_beat  byte_q[$];
    t_out_beat hash_due_q[$];

    // Predicted register contents and running hashes.
    logic [HASH_W-1:0] base_reg = BASE_RST;
    logic [HASH_W-1:0] mod_one_reg = MOD_ONE_RST;
    logic [HASH_W-1:0] mod_two_reg = MOD_TWO_RST;
    logic [HASH_W-1:0] hash_one = '0;
    logic [HASH_W-1:0] hash_two = '0;

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int err_count = 0;

    dual_modulus_polynomial_hash_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // One polynomial step: the full product plus the byte, reduced by the modulus.
    // A modulus of 0 or 1 behaves as 1.
    function automatic logic [HASH_W-1:0] poly_fold(logic [HASH_W-1:0] h,
                                                    logic [HASH_W-1:0] mult,
                                                    logic [HASH_W-1:0] modv,
                                                    logic [BYTE_W-1:0] ch);
        logic [63:0] m;
        logic [63:0] acc;
        m   = (modv < 2) ? 64'd1 : 64'(modv);
        acc = 64'(h) * 64'(mult) + 64'(ch);
        return HASH_W'(acc % m);
    endfunction

    // Update the running hashes for an accepted beat and queue the result it should give.
    task automatic absorb_byte(t_in_beat b);
        t_out_beat r;
        r.bad_char = (b.byte_in > ASCII_MAX);
        if (!r.bad_char) begin
            hash_one = poly_fold(b.start_new ? '0 : hash_one, base_reg, mod_one_reg, b.byte_in);
            hash_two = poly_fold(b.start_new ? '0 : hash_two, base_reg, mod_two_reg, b.byte_in);
        end
        r.hash_first  = hash_one;
        r.hash_second = hash_two;
        hash_due_q.push_back(r);
    endtask

    task automatic report_mismatch(string what);
        $display("MISMATCH @ %0t ns: %s", $time, what);
        err_count++;
    endtask

    // Driver: presents queued bytes, holding each beat while it is stalled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                absorb_byte(i_in_beat);
            if (!i_in_valid || !o_in_stall) begin
                if (byte_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                    i_in_beat  <= byte_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result beat against the oldest prediction.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (hash_due_q.size() == 0) begin
                    report_mismatch("result beat with no byte outstanding");
                end else begin
                    want = hash_due_q.pop_front();
                    if (o_out_beat.hash_first !== want.hash_first)
                        report_mismatch($sformatf("hash_first %0d, expected %0d",
                                                  o_out_beat.hash_first, want.hash_first));
                    if (o_out_beat.hash_second !== want.hash_second)
                        report_mismatch($sformatf("hash_second %0d, expected %0d",
                                                  o_out_beat.hash_second, want.hash_second));
                    if (o_out_beat.bad_char !== want.bad_char)
                        report_mismatch($sformatf("bad_char %0b, expected %0b",
                                                  o_out_beat.bad_char, want.bad_char));
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
        end
    end

    // Writes one register and mirrors it in the predictor; only called while idle.
    task automatic cfg_write(t_cfg_idx idx, logic [HASH_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_BASE:    base_reg = val;
            CFG_MOD_ONE: mod_one_reg = val;
            CFG_MOD_TWO: mod_two_reg = val;
            default: ;
        endcase
    endtask

    task automatic push_byte(logic [BYTE_W-1:0] ch, logic start);
        t_in_beat b;
        b.byte_in   = ch;
        b.start_new = start;
        byte_q.push_back(b);
    endtask

    // Waits until every byte has been sent and every result has come back.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (byte_q.size() != 0 || i_in_valid || hash_due_q.size() != 0);
    endtask

    // Register values weighted towards the extremes.
    function automatic logic [HASH_W-1:0] pick_reg_value();
        case ($urandom_range(0, 7))
            0:       return HASH_W'($urandom_range(0, 2));
            1:       return '1;
            2:       return HASH_W'($urandom_range(2, 300));
            default: return HASH_W'($urandom);
        endcase
    endfunction

    // Queues roughly n bytes: mostly whole strings opened by a start flag, with some
    // non-ASCII noise and stray start flags mixed in.
    task automatic queue_random_text(int n);
        int sent;
        int len;
        logic [BYTE_W-1:0] ch;
        logic start;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 9) < 8) begin
                len = $urandom_range(1, 24);
                for (int i = 0; i < len; i++) begin
                    ch    = BYTE_W'($urandom_range(0, 127));
                    start = (i == 0) || ($urandom_range(0, 39) == 0);
                    if ($urandom_range(0, 19) == 0) begin
                        ch    = BYTE_W'($urandom_range(128, 255));
                        start = 1'($urandom_range(0, 1));
                    end
                    push_byte(ch, start);
                end
            end else begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    push_byte(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            sent += len;
        end
    endtask

    // Stimulus sequence.
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: ASCII limits, non-ASCII bytes with and without a start flag.
        @(negedge i_clk);
        snd_idle_pct = 14;
        rcv_idle_pct = 87;
        push_byte(8'd0, 1'b1);
        push_byte(8'd127, 1'b0);
        push_byte(8'd65, 1'b0);
        push_byte(8'd128, 1'b1);
        push_byte(8'd255, 1'b0);
        push_byte(8'h55, 1'b0);
        push_byte(8'hAA, 1'b0);
        push_byte(8'h2A, 1'b1);
        push_byte(8'd1, 1'b0);
        wait_drained();

        // Base of zero; moduli of one and zero both act as one.
        cfg_write(CFG_BASE, '0);
        cfg_write(CFG_MOD_ONE, HASH_W'(1));
        cfg_write(CFG_MOD_TWO, '0);
        @(negedge i_clk);
        push_byte(8'd100, 1'b1);
        push_byte(8'd127, 1'b0);
        push_byte(8'd5, 1'b0);
        push_byte(8'd255, 1'b0);
        wait_drained();

        // Largest base and modulus, smallest real modulus.
        cfg_write(CFG_BASE, '1);
        cfg_write(CFG_MOD_ONE, '1);
        cfg_write(CFG_MOD_TWO, HASH_W'(2));
        @(negedge i_clk);
        push_byte(8'd127, 1'b1);
        push_byte(8'd127, 1'b0);
        push_byte(8'd127, 1'b0);
        push_byte(8'd0, 1'b0);
        push_byte(8'd1, 1'b0);
        wait_drained();

        // Shrink a modulus mid-stream so the stored hash exceeds it.
        cfg_write(CFG_MOD_ONE, HASH_W'(1000));
        cfg_write(CFG_MOD_TWO, '1);
        @(negedge i_clk);
        push_byte(8'd7, 1'b0);
        push_byte(8'd127, 1'b0);
        push_byte(8'd200, 1'b0);
        wait_drained();

        // Random settings and text, three phases per idling pattern.
        for (int p = 0; p < 9; p++) begin
            cfg_write(CFG_BASE, pick_reg_value());
            cfg_write(CFG_MOD_ONE, pick_reg_value());
            cfg_write(CFG_MOD_TWO, pick_reg_value());
            @(negedge i_clk);
            case (p / 3)
                0: begin
                    snd_idle_pct = 14;
                    rcv_idle_pct = 87;
                end
                1: begin
                    snd_idle_pct = 87;
                    rcv_idle_pct = 14;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            queue_random_text(150);
            wait_drained();
        end

        // Let any stray result beat show itself before the verdict.
        repeat (70) @(posedge i_clk);
        if (err_count == 0)
            $display("** dual_modulus_polynomial_hash_top: PASSED **");
        else
            $display("** dual_modulus_polynomial_hash_top: FAILED **");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #8000000;
        $display("** dual_modulus_polynomial_hash_top: FAILED **");
        $finish;
    end

endmodule
